FILE: design/ccc_pkg.sv
package ccc_pkg;

    // Field widths
    localparam int WORD_W          = 15;
    localparam int MSG_W           = 14;
    localparam int LEN_W           = 4;
    localparam int MAX_CODE_LENGTH = 15;

    // Division pipeline: bits of the word absorbed per stage, and stage count
    localparam int DIV_STEPS  = 5;
    localparam int DIV_STAGES = WORD_W / DIV_STEPS;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Cycles for the derived degree and the column table to follow a write
    localparam int                SETTLE_W      = 5;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 5'd17;

    // Reset values of the registers
    localparam logic [LEN_W-1:0]  RST_CODE_LENGTH    = 4'd7;
    localparam logic [LEN_W-1:0]  RST_MESSAGE_LENGTH = 4'd4;
    localparam logic [WORD_W-1:0] RST_GENERATOR_POLY = 15'd11;

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // Register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_CODE_LENGTH    = 2'd0,
        REG_MESSAGE_LENGTH = 2'd1,
        REG_GENERATOR_POLY = 2'd2
    } t_reg_idx;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [LEN_W-1:0]  t_len;

    typedef struct packed {
        logic  opcode;
        t_word data_word;
    } t_in_item;

    typedef struct packed {
        t_word             code_word;
        logic [MSG_W-1:0]  message;
        logic              error_found;
        t_len              error_position;
        logic              uncorrectable;
    } t_out_item;

    // Item travelling through the division stages
    typedef struct packed {
        logic  opcode;
        t_word word;    // received word, or message placed above the check bits
        t_word shreg;   // word to divide, bits still to be absorbed from the top
        t_word rem;     // running remainder
    } t_div_item;

    // Configuration as seen by the datapath
    typedef struct packed {
        t_len                         code_length;
        t_len                         message_length;
        t_len                         check_length;
        t_word                        generator_poly;
        t_len                         degree;
        logic                         cfg_ok;
        logic                         settled;
        logic [WORD_W-1:0][WORD_W-1:0] cols;
    } t_cfg_view;

    // One step of GF(2) long division: shift in a bit, reduce by g
    function automatic t_word div_step(t_word rem, logic bit_in, t_word g, t_len dg);
        t_word t;
        t = {rem[WORD_W-2:0], bit_in};
        if (t[dg]) begin
            t = t ^ g;
        end
        return t;
    endfunction

endpackage

FILE: design/ccc_cfg.sv
module ccc_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ccc_pkg::ADDR_W-1:0] paddr,
    input  logic [ccc_pkg::DATA_W-1:0] pwdata,
    output logic [ccc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output ccc_pkg::t_cfg_view        o_cfg
);
    import ccc_pkg::*;

    t_len                 r_code_length;
    t_len                 r_message_length;
    t_word                r_generator_poly;
    t_len                 r_degree;
    logic                 r_cfg_ok;
    logic [SETTLE_W-1:0]  r_settle;
    t_word                r_col [WORD_W];

    t_len                 n_degree;
    logic                 n_cfg_ok;
    logic                 wr_en;
    t_reg_idx             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_length    <= RST_CODE_LENGTH;
            r_message_length <= RST_MESSAGE_LENGTH;
            r_generator_poly <= RST_GENERATOR_POLY;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CODE_LENGTH:    r_code_length    <= pwdata[LEN_W-1:0];
                REG_MESSAGE_LENGTH: r_message_length <= pwdata[LEN_W-1:0];
                REG_GENERATOR_POLY: r_generator_poly <= pwdata[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_CODE_LENGTH:    prdata = DATA_W'(r_code_length);
            REG_MESSAGE_LENGTH: prdata = DATA_W'(r_message_length);
            REG_GENERATOR_POLY: prdata = DATA_W'(r_generator_poly);
            default:            prdata = '0;
        endcase
    end

    // Derive degree of g and check the configuration
    always_comb begin
        n_degree = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (r_generator_poly[i]) begin
                n_degree = LEN_W'(i);
            end
        end
        n_cfg_ok = (r_code_length >= 4'd3)
                && ({1'b0, r_code_length} <= 5'(MAX_CODE_LENGTH))
                && (r_message_length != '0)
                && (r_message_length < r_code_length)
                && (r_generator_poly != '0)
                && (n_degree == r_code_length - r_message_length);
    end

    always_ff @(posedge i_clk) begin
        r_degree <= n_degree;
        r_cfg_ok <= n_cfg_ok;
    end

    // Column table: column i is x^i mod g, one reduction step per register
    always_ff @(posedge i_clk) begin
        r_col[0] <= t_word'(1);
        for (int i = 1; i < WORD_W; i++) begin
            r_col[i] <= div_step(r_col[i-1], 1'b0, r_generator_poly, r_degree);
        end
    end

    // Hold off items until the derived values have caught up with a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= SETTLE_CYCLES;
        end else if (wr_en) begin
            r_settle <= SETTLE_CYCLES;
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    always_comb begin
        o_cfg.code_length    = r_code_length;
        o_cfg.message_length = r_message_length;
        o_cfg.check_length   = r_code_length - r_message_length;
        o_cfg.generator_poly = r_generator_poly;
        o_cfg.degree         = r_degree;
        o_cfg.cfg_ok         = r_cfg_ok;
        o_cfg.settled        = (r_settle == '0);
        for (int i = 0; i < WORD_W; i++) begin
            o_cfg.cols[i] = r_col[i];
        end
    end

endmodule

FILE: design/ccc_div_stage.sv
module ccc_div_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccc_pkg::t_cfg_view  i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  ccc_pkg::t_div_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ccc_pkg::t_div_item  o_item
);
    import ccc_pkg::*;

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Absorb the next bits of the aligned word, most significant first
    always_comb begin
        n_item = i_item;
        for (int s = 0; s < DIV_STEPS; s++) begin
            n_item.rem   = div_step(n_item.rem, n_item.shreg[WORD_W-1],
                                    i_cfg.generator_poly, i_cfg.degree);
            n_item.shreg = {n_item.shreg[WORD_W-2:0], 1'b0};
        end
    end

    // Advance when the next stage can take the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: design/ccc_fix_stage.sv
module ccc_fix_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ccc_pkg::t_cfg_view  i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  ccc_pkg::t_div_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output ccc_pkg::t_out_item  o_item
);
    import ccc_pkg::*;

    logic      r_valid;
    t_out_item r_item;
    t_out_item n_item;

    logic      hit;
    t_len      hit_idx;
    t_word     cw;
    t_word     msg_full;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        // Match the syndrome against the columns; the highest bit wins,
        // which is the lowest position counted from the top
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if ((LEN_W'(i) < i_cfg.code_length) && (i_cfg.cols[i] == i_item.rem)) begin
                hit     = 1'b1;
                hit_idx = LEN_W'(i);
            end
        end

        cw                    = i_item.word;
        n_item.error_found    = 1'b0;
        n_item.error_position = '0;
        n_item.uncorrectable  = 1'b0;

        if (!i_cfg.cfg_ok) begin
            cw                   = '0;
            n_item.uncorrectable = 1'b1;
        end else if (i_item.opcode == OP_ENCODE) begin
            cw = i_item.word | i_item.rem;
        end else if (i_item.rem != '0) begin
            n_item.error_found = 1'b1;
            if (hit) begin
                cw                    = i_item.word ^ (t_word'(1) << hit_idx);
                n_item.error_position = i_cfg.code_length - 1'b1 - hit_idx;
            end else begin
                n_item.uncorrectable = 1'b1;
            end
        end

        // Message is the top k bits of the n-bit word
        msg_full         = cw >> i_cfg.check_length;
        n_item.code_word = cw;
        n_item.message   = msg_full[MSG_W-1:0];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: design/cyclic_code_codec_unit.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in_data   (t_in_item)
// output    out        o_out_valid / i_out_ready o_out_data  (t_out_item)
// config    in         psel/penable/pwrite/pready paddr, pwdata, prdata (APB)
//
// One item per cycle sustained while the output is not stalled and the input is
// not held off; output valid follows the input transfer through the input
// register, three division stages of five bits each, and the correction stage
// with output register. After reset and after every register write the input
// is held off while the generator degree and column table settle.
// A stall at the output back-pressures each stage in turn; nothing is lost
// or repeated, and empty stages keep accepting.
module cyclic_code_codec_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccc_pkg::ADDR_W-1:0] paddr,
    input  logic [ccc_pkg::DATA_W-1:0] pwdata,
    output logic [ccc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ccc_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ccc_pkg::t_out_item         o_out_data
);
    import ccc_pkg::*;

    t_cfg_view cfg;

    logic      r_s0_valid;
    t_div_item r_s0_item;
    t_div_item n_s0_item;
    logic      s0_ready;

    logic      st_valid [DIV_STAGES+1];
    logic      st_ready [DIV_STAGES+1];
    t_div_item st_item  [DIV_STAGES+1];

    t_word     nmask;
    t_word     kmask;
    t_word     msg;
    t_word     rx;

    ccc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input register: mask the data and hand the whole word to the division
    assign s0_ready   = !r_s0_valid || st_ready[0];
    assign o_in_ready = s0_ready && cfg.settled;

    always_comb begin
        nmask = t_word'({WORD_W{1'b1}}) >> (LEN_W'(WORD_W) - cfg.code_length);
        kmask = t_word'({WORD_W{1'b1}}) >> (LEN_W'(WORD_W) - cfg.message_length);
        msg   = i_in_data.data_word & kmask;
        rx    = i_in_data.data_word & nmask;

        n_s0_item.opcode = i_in_data.opcode;
        n_s0_item.rem    = '0;
        if (i_in_data.opcode == OP_ENCODE) begin
            n_s0_item.word  = msg << cfg.check_length;
            n_s0_item.shreg = msg << cfg.check_length;
        end else begin
            n_s0_item.word  = rx;
            n_s0_item.shreg = rx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (s0_ready) begin
            r_s0_valid <= i_in_valid && cfg.settled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s0_item <= n_s0_item;
        end
    end

    assign st_valid[0] = r_s0_valid;
    assign st_item[0]  = r_s0_item;

    // Division stages
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        ccc_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cfg),
            .i_valid (st_valid[g]),
            .o_ready (st_ready[g]),
            .i_item  (st_item[g]),
            .o_valid (st_valid[g+1]),
            .i_ready (st_ready[g+1]),
            .o_item  (st_item[g+1])
        );
    end

    // Syndrome match, correction and output register
    ccc_fix_stage u_fix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (st_valid[DIV_STAGES]),
        .o_ready (st_ready[DIV_STAGES]),
        .i_item  (st_item[DIV_STAGES]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

endmodule
